FILE: design/szhp_pkg.sv
// Package: payload types, property ids, phase codes and status codes for the coded-header probe.
`timescale 1ns / 1ps
package szhp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] coder_id;
    logic        coder_seen;
    logic [3:0]  lit_ctx_bits;
    logic [2:0]  lit_pos_bits;
    logic [2:0]  pos_bits;
    logic        props_seen;
    logic [63:0] header_len;
    logic [63:0] pack_offset;
    logic [63:0] packed_len;
  } out_item_t;

  localparam logic [7:0] ID_END                = 8'h00;
  localparam logic [7:0] ID_PACK_INFO          = 8'h06;
  localparam logic [7:0] ID_UNPACK_INFO        = 8'h07;
  localparam logic [7:0] ID_SIZE               = 8'h09;
  localparam logic [7:0] ID_FOLDER             = 8'h0B;
  localparam logic [7:0] ID_CODERS_UNPACK_SIZE = 8'h0C;
  localparam logic [31:0] LZMA_CODER           = 32'h0003_0101;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ENDED = 3'd1;
  localparam logic [2:0] ST_STEPS = 3'd2;
  localparam logic [2:0] ST_STRUCT = 3'd3;
  localparam logic [2:0] ST_PROPS = 3'd4;

  localparam logic [4:0] PH_FIRST_ID    = 5'd0;
  localparam logic [4:0] PH_PACK_POS    = 5'd1;
  localparam logic [4:0] PH_PACK_COUNT  = 5'd2;
  localparam logic [4:0] PH_PACK_SEARCH = 5'd3;
  localparam logic [4:0] PH_PACK_SIZES  = 5'd4;
  localparam logic [4:0] PH_UNPACK_ID   = 5'd5;
  localparam logic [4:0] PH_FOLDER_ID   = 5'd6;
  localparam logic [4:0] PH_NUM_FOLDERS = 5'd7;
  localparam logic [4:0] PH_EXTERNAL    = 5'd8;
  localparam logic [4:0] PH_NUM_CODERS  = 5'd9;
  localparam logic [4:0] PH_FLAGS       = 5'd10;
  localparam logic [4:0] PH_CODER_ID    = 5'd11;
  localparam logic [4:0] PH_PROP_LEN    = 5'd12;
  localparam logic [4:0] PH_PROP_BYTES  = 5'd13;
  localparam logic [4:0] PH_SIZE_SEARCH = 5'd14;
  localparam logic [4:0] PH_UNPACK_SIZE = 5'd15;

  localparam logic [0:0] CFG_STEP_LIMIT = 1'b0;
  localparam logic [0:0] CFG_PACK_LIMIT = 1'b1;

  // Result of the number decoder for one byte.
  typedef struct packed {
    logic        done;
    logic [63:0] value;
  } num_res_t;

  // LZMA property byte split; table-free constant divisions.
  typedef struct packed {
    logic [3:0] lc;
    logic [2:0] lp;
    logic [2:0] pb;
  } lzma_props_t;

endpackage

FILE: design/szhp_number.sv
// Module: 7z variable-length number decoder, one byte per cycle.
`timescale 1ns / 1ps
module szhp_number (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              feed_i,
  input  logic              clear_i,
  input  logic [7:0]        byte_i,
  output szhp_pkg::num_res_t res_o
);

  logic [7:0]  lead_q, lead_d;
  logic [3:0]  idx_q, idx_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  idx_inc;
  logic [7:0]  mask;
  logic [63:0] acc_new;
  logic [63:0] top;

  always_comb begin
    lead_d  = lead_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    res_o   = '0;
    idx_inc = idx_q + 4'd1;
    mask    = 8'h80 >> idx_inc;
    acc_new = acc_q | ({56'd0, byte_i} << {idx_q[2:0], 3'b000});
    top     = {56'd0, lead_q & (mask - 8'd1)} << {idx_inc[2:0], 3'b000};
    if (feed_i) begin
      if (!lead_q[7]) begin
        if (!byte_i[7]) begin
          res_o.done  = 1'b1;
          res_o.value = {57'd0, byte_i[6:0]};
        end else begin
          lead_d = byte_i;
          idx_d  = 4'd0;
          acc_d  = '0;
        end
      end else begin
        acc_d = acc_new;
        idx_d = idx_inc;
        if (idx_inc[3]) begin
          res_o.done  = 1'b1;
          res_o.value = acc_new;
          lead_d      = '0;
        end else if ((lead_q & mask) == 8'd0) begin
          res_o.done  = 1'b1;
          res_o.value = acc_new + top;
          lead_d      = '0;
        end
      end
    end
    if (clear_i) begin
      lead_d = '0;
      idx_d  = '0;
      acc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      idx_q  <= '0;
      acc_q  <= '0;
    end else begin
      lead_q <= lead_d;
      idx_q  <= idx_d;
      acc_q  <= acc_d;
    end
  end

endmodule

FILE: design/sevenzip_coded_header_probe.sv
// Top level: 7z coded-header probe, one byte item per cycle while the input does not stall, with a registered result.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  szhp_pkg::in_item_t
//   out      output     out_valid_o / out_stall_i szhp_pkg::out_item_t
//   cfg      input      cfg_we_i                 cfg_index_i, cfg_data_i
//
// Each byte item is settled by the phase machine and the number decoder between
// the input and the result register, so the rate is one item per clock while the
// input does not stall. A result appears in the output register on the cycle after the
// byte that settles it. Reset clears all control state and loads the register
// defaults. The input stalls only while a result is held and the output stalls.
`timescale 1ns / 1ps
module sevenzip_coded_header_probe #(
  parameter int SIGNATURE_HEADER_LEN = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  szhp_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output szhp_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  localparam logic [63:0] HdrLen = 64'(SIGNATURE_HEADER_LEN);

  logic [7:0]  step_limit_q;
  logic [15:0] pack_limit_q;

  logic [4:0]  phase_q, phase_d;
  logic [7:0]  steps_q, steps_d;
  logic [63:0] pack_pos_q, pack_pos_d;
  logic [15:0] pack_cnt_q, pack_cnt_d;
  logic [15:0] size_idx_q, size_idx_d;
  logic [63:0] first_size_q, first_size_d;
  logic [7:0]  flags_q, flags_d;
  logic [2:0]  id_left_q, id_left_d;
  logic [63:0] skip_q, skip_d;
  logic        done_q, done_d;
  logic [31:0] coder_q, coder_d;
  logic        coder_seen_q, coder_seen_d;
  szhp_pkg::lzma_props_t props_q, props_d;
  logic        props_seen_q, props_seen_d;
  logic        pending_q, pending_d;
  logic [63:0] unpack_q, unpack_d;

  logic        accept;
  logic        num_feed;
  szhp_pkg::num_res_t num;
  logic [7:0]  b;
  logic [3:0]  st;          // bit 3 means a verdict
  logic [7:0]  b_div9;
  szhp_pkg::lzma_props_t split;
  logic [64:0] off_sum;
  szhp_pkg::out_item_t res;
  logic        out_valid_q;
  szhp_pkg::out_item_t out_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign b          = in_data_i.data_byte;

  // Phases that feed the shared number decoder.
  assign num_feed = accept && !done_q &&
                    (phase_q == szhp_pkg::PH_PACK_POS || phase_q == szhp_pkg::PH_PACK_COUNT ||
                     phase_q == szhp_pkg::PH_PACK_SIZES || phase_q == szhp_pkg::PH_NUM_FOLDERS ||
                     phase_q == szhp_pkg::PH_NUM_CODERS || phase_q == szhp_pkg::PH_PROP_LEN ||
                     phase_q == szhp_pkg::PH_UNPACK_SIZE);

  szhp_number u_number (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .feed_i  (num_feed),
    .clear_i (accept && in_data_i.last_byte),
    .byte_i  (b),
    .res_o   (num)
  );

  // Property split by constants: divide by 9 through a reciprocal product.
  always_comb begin
    logic [15:0] prod;
    logic [7:0]  rem9;
    logic [8:0]  prod5;
    logic [7:0]  rem5;
    prod   = 16'(b) * 16'd57;
    b_div9 = {3'd0, prod[13:9]};
    rem9   = b - 8'(b_div9 * 8'd9);
    if (rem9 >= 8'd9) begin
      b_div9 = b_div9 + 8'd1;
      rem9   = rem9 - 8'd9;
    end
    // The quotient by 9 is at most 28, where (q * 13) >> 6 gives q / 5 exactly.
    prod5 = {4'd0, b_div9[4:0]} * 9'd13;
    rem5  = b_div9 - {3'd0, prod5[8:6], 2'b00} - {5'd0, prod5[8:6]};
    split.lc = rem9[3:0];
    split.lp = rem5[2:0];
    split.pb = prod5[8:6];
  end

  always_comb begin
    phase_d = phase_q; steps_d = steps_q; pack_pos_d = pack_pos_q;
    pack_cnt_d = pack_cnt_q; size_idx_d = size_idx_q; first_size_d = first_size_q;
    flags_d = flags_q; id_left_d = id_left_q; skip_d = skip_q; done_d = done_q;
    coder_d = coder_q; coder_seen_d = coder_seen_q; props_d = props_q;
    props_seen_d = props_seen_q; pending_d = pending_q; unpack_d = unpack_q;
    st = 4'd0;
    if (accept && !done_q) begin
      case (phase_q)
        szhp_pkg::PH_FIRST_ID: begin
          if (b == szhp_pkg::ID_PACK_INFO) phase_d = szhp_pkg::PH_PACK_POS;
          else if (b == szhp_pkg::ID_UNPACK_INFO) phase_d = szhp_pkg::PH_FOLDER_ID;
          else st = {1'b1, szhp_pkg::ST_STRUCT};
        end
        szhp_pkg::PH_PACK_POS: begin
          if (num.done) begin
            pack_pos_d = num.value;
            phase_d    = szhp_pkg::PH_PACK_COUNT;
          end
        end
        szhp_pkg::PH_PACK_COUNT: begin
          if (num.done) begin
            if (num.value == 64'd0 || num.value > {48'd0, pack_limit_q})
              st = {1'b1, szhp_pkg::ST_STRUCT};
            else begin
              pack_cnt_d = num.value[15:0];
              phase_d    = szhp_pkg::PH_PACK_SEARCH;
            end
          end
        end
        szhp_pkg::PH_PACK_SEARCH: begin
          if ({1'b0, steps_q} + 9'd1 > {1'b0, step_limit_q}) st = {1'b1, szhp_pkg::ST_STEPS};
          else begin
            steps_d = steps_q + 8'd1;
            if (b == szhp_pkg::ID_END) phase_d = szhp_pkg::PH_UNPACK_ID;
            else if (b == szhp_pkg::ID_SIZE) begin
              size_idx_d = '0;
              phase_d    = szhp_pkg::PH_PACK_SIZES;
            end
          end
        end
        szhp_pkg::PH_PACK_SIZES: begin
          if (num.done) begin
            if (size_idx_q == 16'd0) first_size_d = num.value;
            size_idx_d = size_idx_q + 16'd1;
            if (size_idx_d >= pack_cnt_q) phase_d = szhp_pkg::PH_PACK_SEARCH;
          end
        end
        szhp_pkg::PH_UNPACK_ID: begin
          if (b != szhp_pkg::ID_UNPACK_INFO) st = {1'b1, szhp_pkg::ST_STRUCT};
          else phase_d = szhp_pkg::PH_FOLDER_ID;
        end
        szhp_pkg::PH_FOLDER_ID: begin
          if (b != szhp_pkg::ID_FOLDER) st = {1'b1, szhp_pkg::ST_STRUCT};
          else phase_d = szhp_pkg::PH_NUM_FOLDERS;
        end
        szhp_pkg::PH_NUM_FOLDERS: if (num.done) phase_d = szhp_pkg::PH_EXTERNAL;
        szhp_pkg::PH_EXTERNAL:    phase_d = szhp_pkg::PH_NUM_CODERS;
        szhp_pkg::PH_NUM_CODERS:  if (num.done) phase_d = szhp_pkg::PH_FLAGS;
        szhp_pkg::PH_FLAGS: begin
          flags_d   = b;
          id_left_d = b[2:0];
          if (b[3:0] == 4'd0 || b[3:0] > 4'd4) st = {1'b1, szhp_pkg::ST_STRUCT};
          else begin
            coder_d = '0;
            phase_d = szhp_pkg::PH_CODER_ID;
          end
        end
        szhp_pkg::PH_CODER_ID: begin
          coder_d   = {coder_q[23:0], b};
          id_left_d = id_left_q - 3'd1;
          if (id_left_d == 3'd0) begin
            coder_seen_d = 1'b1;
            phase_d = flags_q[5] ? szhp_pkg::PH_PROP_LEN : szhp_pkg::PH_SIZE_SEARCH;
          end
        end
        szhp_pkg::PH_PROP_LEN: begin
          if (num.done) begin
            skip_d    = num.value;
            pending_d = (coder_q == szhp_pkg::LZMA_CODER) && (num.value != 64'd0);
            phase_d   = (num.value != 64'd0) ? szhp_pkg::PH_PROP_BYTES
                                             : szhp_pkg::PH_SIZE_SEARCH;
          end
        end
        szhp_pkg::PH_PROP_BYTES: begin
          if (pending_q) begin
            pending_d    = 1'b0;
            props_d      = split;
            props_seen_d = 1'b1;
            if (split.pb > 3'd4) st = {1'b1, szhp_pkg::ST_PROPS};
          end
          skip_d = skip_q - 64'd1;
          if (skip_d == 64'd0) phase_d = szhp_pkg::PH_SIZE_SEARCH;
        end
        szhp_pkg::PH_SIZE_SEARCH: begin
          if ({1'b0, steps_q} + 9'd1 > {1'b0, step_limit_q}) st = {1'b1, szhp_pkg::ST_STEPS};
          else begin
            steps_d = steps_q + 8'd1;
            if (b == szhp_pkg::ID_CODERS_UNPACK_SIZE) phase_d = szhp_pkg::PH_UNPACK_SIZE;
            else if (b == szhp_pkg::ID_END) st = {1'b1, szhp_pkg::ST_STRUCT};
          end
        end
        szhp_pkg::PH_UNPACK_SIZE: begin
          if (num.done) begin
            unpack_d = num.value;
            st       = {1'b1, szhp_pkg::ST_OK};
          end
        end
        default: st = {1'b1, szhp_pkg::ST_STRUCT};
      endcase
      if (!st[3] && in_data_i.last_byte) st = {1'b1, szhp_pkg::ST_ENDED};
      if (st[3]) done_d = 1'b1;
    end

    // The result is built from the state as it stands after this byte.
    off_sum = {1'b0, pack_pos_d} + {1'b0, HdrLen};
    res.status       = st[2:0];
    res.coder_id     = coder_seen_d ? coder_d : 32'd0;
    res.coder_seen   = coder_seen_d;
    res.lit_ctx_bits = props_seen_d ? props_d.lc : 4'd0;
    res.lit_pos_bits = props_seen_d ? props_d.lp : 3'd0;
    res.pos_bits     = props_seen_d ? props_d.pb : 3'd0;
    res.props_seen   = props_seen_d;
    res.header_len   = (st[2:0] == szhp_pkg::ST_OK) ? unpack_d : 64'd0;
    res.pack_offset  = (st[2:0] != szhp_pkg::ST_OK) ? 64'd0 :
                       off_sum[64] ? {64{1'b1}} : off_sum[63:0];
    res.packed_len   = (st[2:0] == szhp_pkg::ST_OK) ? first_size_d : 64'd0;

    // A region boundary returns everything but the registers to reset.
    if (accept && in_data_i.last_byte) begin
      phase_d = szhp_pkg::PH_FIRST_ID; steps_d = '0; pack_pos_d = '0; pack_cnt_d = '0;
      size_idx_d = '0; first_size_d = '0; flags_d = '0; id_left_d = '0; skip_d = '0;
      done_d = 1'b0; coder_d = '0; coder_seen_d = 1'b0; props_d = '0;
      props_seen_d = 1'b0; pending_d = 1'b0; unpack_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_limit_q <= 8'd64;
      pack_limit_q <= 16'd4096;
      phase_q <= szhp_pkg::PH_FIRST_ID; steps_q <= '0; pack_pos_q <= '0; pack_cnt_q <= '0;
      size_idx_q <= '0; first_size_q <= '0; flags_q <= '0; id_left_q <= '0; skip_q <= '0;
      done_q <= 1'b0; coder_q <= '0; coder_seen_q <= 1'b0; props_q <= '0;
      props_seen_q <= 1'b0; pending_q <= 1'b0; unpack_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          szhp_pkg::CFG_STEP_LIMIT: step_limit_q <= cfg_data_i[7:0];
          szhp_pkg::CFG_PACK_LIMIT: pack_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      phase_q <= phase_d; steps_q <= steps_d; pack_pos_q <= pack_pos_d;
      pack_cnt_q <= pack_cnt_d; size_idx_q <= size_idx_d; first_size_q <= first_size_d;
      flags_q <= flags_d; id_left_q <= id_left_d; skip_q <= skip_d; done_q <= done_d;
      coder_q <= coder_d; coder_seen_q <= coder_seen_d; props_q <= props_d;
      props_seen_q <= props_seen_d; pending_q <= pending_d; unpack_q <= unpack_d;
      if (st[3]) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st[3]) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A result is only produced from an accepted item.
  a_res_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st[3] |-> accept) else $error("result without an item");
  // A verdict is not given twice within one region.
  a_one_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !st[3]) else $error("second verdict in a region");
  // A held result is not overwritten while the output stalls.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result lost");

endmodule

FILE: verif/sevenzip_coded_header_checker.sv
// Checker: watches the byte and result channels, predicts each result and compares it.
`timescale 1ns / 1ps
module sevenzip_coded_header_checker #(
  parameter int SIGNATURE_HEADER_LEN = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  szhp_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  szhp_pkg::out_item_t out_data_i,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output int                  errors_o,
  output int                  pending_o
);

  logic [7:0]  lim_steps;
  logic [15:0] lim_packs;

  logic [4:0]  ph;
  logic [7:0]  steps;
  logic [7:0]  lead;
  logic [3:0]  nidx;
  logic [63:0] acc;
  logic [63:0] ppos;
  logic [15:0] pcount;
  logic [15:0] sidx;
  logic [63:0] psize;
  logic [7:0]  cflags;
  logic [2:0]  idleft;
  logic [63:0] skip;
  logic        settled;
  logic [31:0] cid;
  logic        cid_ok;
  logic [3:0]  lc;
  logic [2:0]  lp;
  logic [2:0]  pb;
  logic        props_ok;
  logic        props_wait;
  logic [63:0] usize;

  szhp_pkg::out_item_t expected_results[$];

  task automatic clear_region();
    ph = szhp_pkg::PH_FIRST_ID; steps = '0; lead = '0; nidx = '0; acc = '0; ppos = '0;
    pcount = '0; sidx = '0; psize = '0; cflags = '0; idleft = '0; skip = '0;
    settled = 1'b0; cid = '0; cid_ok = 1'b0; lc = '0; lp = '0; pb = '0;
    props_ok = 1'b0; props_wait = 1'b0; usize = '0;
  endtask

  // Variable-length number decoder; returns 1 when v holds a whole number.
  function automatic bit take_number(input logic [7:0] b, output logic [63:0] v);
    logic [7:0] mask;
    v = '0;
    if (!lead[7]) begin
      if (!b[7]) begin
        v = {57'd0, b[6:0]};
        return 1;
      end
      lead = b; nidx = '0; acc = '0;
      return 0;
    end
    acc = acc | ({56'd0, b} << (8 * nidx));
    nidx = nidx + 4'd1;
    if (nidx >= 4'd8) begin
      v = acc; lead = '0;
      return 1;
    end
    mask = 8'h80 >> nidx;
    if ((lead & mask) == 8'd0) begin
      v = acc + ({56'd0, lead & (mask - 8'd1)} << (8 * nidx));
      lead = '0;
      return 1;
    end
    return 0;
  endfunction

  function automatic bit over_budget();
    if ({1'b0, steps} + 9'd1 > {1'b0, lim_steps}) return 1;
    steps = steps + 8'd1;
    return 0;
  endfunction

  // Advances the parse by one byte; returns -1 while no verdict is settled.
  function automatic int parse_byte(input logic [7:0] b);
    logic [63:0] v;
    case (ph)
      szhp_pkg::PH_FIRST_ID: begin
        if (b == szhp_pkg::ID_PACK_INFO) ph = szhp_pkg::PH_PACK_POS;
        else if (b == szhp_pkg::ID_UNPACK_INFO) ph = szhp_pkg::PH_FOLDER_ID;
        else return szhp_pkg::ST_STRUCT;
      end
      szhp_pkg::PH_PACK_POS: if (take_number(b, v)) begin
        ppos = v; ph = szhp_pkg::PH_PACK_COUNT;
      end
      szhp_pkg::PH_PACK_COUNT: if (take_number(b, v)) begin
        if (v == 64'd0 || v > {48'd0, lim_packs}) return szhp_pkg::ST_STRUCT;
        pcount = v[15:0]; ph = szhp_pkg::PH_PACK_SEARCH;
      end
      szhp_pkg::PH_PACK_SEARCH: begin
        if (over_budget()) return szhp_pkg::ST_STEPS;
        if (b == szhp_pkg::ID_END) ph = szhp_pkg::PH_UNPACK_ID;
        else if (b == szhp_pkg::ID_SIZE) begin
          sidx = '0; ph = szhp_pkg::PH_PACK_SIZES;
        end
      end
      szhp_pkg::PH_PACK_SIZES: if (take_number(b, v)) begin
        if (sidx == 16'd0) psize = v;
        sidx = sidx + 16'd1;
        if (sidx >= pcount) ph = szhp_pkg::PH_PACK_SEARCH;
      end
      szhp_pkg::PH_UNPACK_ID: begin
        if (b != szhp_pkg::ID_UNPACK_INFO) return szhp_pkg::ST_STRUCT;
        ph = szhp_pkg::PH_FOLDER_ID;
      end
      szhp_pkg::PH_FOLDER_ID: begin
        if (b != szhp_pkg::ID_FOLDER) return szhp_pkg::ST_STRUCT;
        ph = szhp_pkg::PH_NUM_FOLDERS;
      end
      szhp_pkg::PH_NUM_FOLDERS: if (take_number(b, v)) ph = szhp_pkg::PH_EXTERNAL;
      szhp_pkg::PH_EXTERNAL: ph = szhp_pkg::PH_NUM_CODERS;
      szhp_pkg::PH_NUM_CODERS: if (take_number(b, v)) ph = szhp_pkg::PH_FLAGS;
      szhp_pkg::PH_FLAGS: begin
        cflags = b;
        if (b[3:0] == 4'd0 || b[3:0] > 4'd4) return szhp_pkg::ST_STRUCT;
        idleft = b[2:0]; cid = '0; ph = szhp_pkg::PH_CODER_ID;
      end
      szhp_pkg::PH_CODER_ID: begin
        cid = {cid[23:0], b};
        idleft = idleft - 3'd1;
        if (idleft == 3'd0) begin
          cid_ok = 1'b1;
          ph = cflags[5] ? szhp_pkg::PH_PROP_LEN : szhp_pkg::PH_SIZE_SEARCH;
        end
      end
      szhp_pkg::PH_PROP_LEN: if (take_number(b, v)) begin
        skip = v;
        props_wait = (cid == szhp_pkg::LZMA_CODER) && v >= 64'd1;
        ph = (v != 64'd0) ? szhp_pkg::PH_PROP_BYTES : szhp_pkg::PH_SIZE_SEARCH;
      end
      szhp_pkg::PH_PROP_BYTES: begin
        if (props_wait) begin
          props_wait = 1'b0;
          lc = 4'(b % 8'd9);
          lp = 3'((b / 8'd9) % 8'd5);
          pb = 3'(b / 8'd45);
          props_ok = 1'b1;
          if (pb > 3'd4) return szhp_pkg::ST_PROPS;
        end
        skip = skip - 64'd1;
        if (skip == 64'd0) ph = szhp_pkg::PH_SIZE_SEARCH;
      end
      szhp_pkg::PH_SIZE_SEARCH: begin
        if (over_budget()) return szhp_pkg::ST_STEPS;
        if (b == szhp_pkg::ID_CODERS_UNPACK_SIZE) ph = szhp_pkg::PH_UNPACK_SIZE;
        else if (b == szhp_pkg::ID_END) return szhp_pkg::ST_STRUCT;
      end
      szhp_pkg::PH_UNPACK_SIZE: if (take_number(b, v)) begin
        usize = v;
        return szhp_pkg::ST_OK;
      end
      default: return szhp_pkg::ST_STRUCT;
    endcase
    return -1;
  endfunction

  function automatic szhp_pkg::out_item_t verdict_item(input logic [2:0] st);
    szhp_pkg::out_item_t r;
    logic [64:0] sum;
    r = '0;
    r.status = st;
    r.coder_id = cid_ok ? cid : '0;
    r.coder_seen = cid_ok;
    if (props_ok) begin
      r.lit_ctx_bits = lc; r.lit_pos_bits = lp; r.pos_bits = pb; r.props_seen = 1'b1;
    end
    if (st == szhp_pkg::ST_OK) begin
      sum = {1'b0, ppos} + 65'(SIGNATURE_HEADER_LEN);
      r.header_len = usize;
      r.pack_offset = sum[64] ? '1 : sum[63:0];
      r.packed_len = psize;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int st;
    szhp_pkg::out_item_t exp_r;
    if (!rst_ni) begin
      lim_steps = 8'd64; lim_packs = 16'd4096;
      clear_region();
      expected_results.delete();
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == szhp_pkg::CFG_STEP_LIMIT) lim_steps = cfg_data_i[7:0];
        else lim_packs = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          errors_o <= errors_o + 1;
          if (errors_o < 10) $display("unexpected result %p", out_data_i);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data_i !== exp_r) begin
            errors_o <= errors_o + 1;
            if (errors_o < 10) $display("mismatch: expected %p got %p", exp_r, out_data_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (!settled) begin
          st = parse_byte(in_data_i.data_byte);
          if (st < 0 && in_data_i.last_byte) st = szhp_pkg::ST_ENDED;
          if (st >= 0) begin
            expected_results.push_back(verdict_item(st[2:0]));
            settled = 1'b1;
          end
        end
        if (in_data_i.last_byte) clear_region();
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

FILE: verif/sevenzip_coded_header_probe_test.sv
// Testbench top: drives byte items and configuration into the probe and gives the verdict.
`timescale 1ns / 1ps
module sevenzip_coded_header_probe_test;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  szhp_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  szhp_pkg::out_item_t out_data_o;
  logic                cfg_we_i;
  logic                cfg_index_i;
  logic [15:0]         cfg_data_i;
  int                  errors;
  int                  pending;

  // Sender gaps and the long receiver hold-off are steered from here.
  bit          hold_output;
  bit          allow_gaps;
  int          idle_cycles;

  // Bytes of one region, built before being sent.
  logic [7:0]  frame_bytes[$];

  sevenzip_coded_header_probe dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  sevenzip_coded_header_checker checker_u (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_i(in_stall_o), .in_data_i(in_data_i),
    .out_valid_i(out_valid_o), .out_stall_i(out_stall_i), .out_data_i(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly no gap, else usually a short one and now and then a long one; none while gaps are off.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (!allow_gaps || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // The receiver stalls at random, and holds off entirely when asked to.
  initial begin : receiver
    int g;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_output) out_stall_i <= 1'b1;
      else begin
        g = gap_length();
        out_stall_i <= (g != 0);
      end
    end
  end

  // The watchdog counts cycles in which neither channel accepts anything.
  initial begin : watchdog
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 4000) begin
        $display("sevenzip_coded_header_probe regression: fail");
        $finish;
      end
    end
  end

  // Offers one byte item and waits until the probe takes it.
  task automatic send_byte(input logic [7:0] b, input bit last);
    int g;
    g = gap_length();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{data_byte: b, last_byte: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_region();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Waits until every result has arrived, then for the result register to drain.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0 || out_valid_o) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Appends a number in the variable-length form, n extra bytes (0..8).
  task automatic put_number(input logic [63:0] v, input int n);
    logic [7:0] first;
    logic [63:0] top;
    if (n >= 8) begin
      frame_bytes.push_back(8'hFF);
      for (int i = 0; i < 8; i++) frame_bytes.push_back(v[8*i +: 8]);
    end else begin
      top = v >> (8 * n);
      first = (8'hFF << (8 - n)) | (top[7:0] & (8'h7F >> n));
      frame_bytes.push_back(first);
      for (int i = 0; i < n; i++) frame_bytes.push_back(v[8*i +: 8]);
    end
  endtask

  task automatic put_random_number(input int span);
    logic [63:0] v;
    int n;
    n = $urandom_range(0, span);
    v = {$urandom, $urandom};
    put_number(v, n);
  endtask

  // Builds a mostly well-formed header; a corruption may be mixed in.
  task automatic build_header(input bit messy);
    int ncount, nsz, coder_len, props_len, noise;
    logic [7:0] flags;
    logic [31:0] coder;
    frame_bytes.delete();
    if ($urandom_range(0, 2) != 0) begin
      frame_bytes.push_back(szhp_pkg::ID_PACK_INFO);
      put_random_number(8);
      ncount = $urandom_range(1, 3);
      put_number(64'(ncount), $urandom_range(0, 1));
      noise = $urandom_range(0, 2);
      repeat (noise) frame_bytes.push_back(8'($urandom_range(16, 255)));
      nsz = $urandom_range(0, 2);
      repeat (nsz) begin
        frame_bytes.push_back(szhp_pkg::ID_SIZE);
        repeat (ncount) put_random_number(8);
      end
      frame_bytes.push_back(szhp_pkg::ID_END);
    end
    frame_bytes.push_back(szhp_pkg::ID_UNPACK_INFO);
    frame_bytes.push_back(szhp_pkg::ID_FOLDER);
    put_number(64'd1, 0);
    frame_bytes.push_back(8'h00);
    put_number(64'd1, 0);
    coder_len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 3;
    props_len = $urandom_range(0, 3);
    flags = {2'b00, props_len != 0 || $urandom_range(0, 1), 1'b0, coder_len[3:0]};
    if ($urandom_range(0, 15) == 0) flags[3:0] = 4'($urandom_range(5, 15));
    frame_bytes.push_back(flags);
    coder = ($urandom_range(0, 2) != 0) ? szhp_pkg::LZMA_CODER : $urandom;
    for (int i = coder_len - 1; i >= 0; i--) frame_bytes.push_back(coder[8*i +: 8]);
    if (flags[5]) begin
      put_number(64'(props_len), 0);
      repeat (props_len) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    noise = $urandom_range(0, 2);
    repeat (noise) frame_bytes.push_back(8'($urandom_range(13, 255)));
    if ($urandom_range(0, 15) == 0) frame_bytes.push_back(szhp_pkg::ID_END);
    frame_bytes.push_back(szhp_pkg::ID_CODERS_UNPACK_SIZE);
    put_random_number(8);
    if (messy) begin
      if ($urandom_range(0, 1)) frame_bytes.delete(frame_bytes.size() - 1);
      else frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom);
    end
    if (frame_bytes.size() == 0 || $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
  endtask

  initial begin : stimulus
    int sent;
    bit hold_started;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = szhp_pkg::CFG_STEP_LIMIT;
    cfg_data_i = '0;
    hold_output = 1'b0;
    allow_gaps = 1'b0;
    hold_started = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed regions at the reset register values.
    frame_bytes = {szhp_pkg::ID_PACK_INFO, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'hFF, 8'hFF, 8'h01, szhp_pkg::ID_SIZE, 8'h05, 8'h42, szhp_pkg::ID_END,
                   szhp_pkg::ID_UNPACK_INFO, szhp_pkg::ID_FOLDER, 8'h01, 8'h00, 8'h01, 8'h23,
                   8'h03, 8'h01, 8'h01, 8'h01, 8'h5D, szhp_pkg::ID_CODERS_UNPACK_SIZE, 8'h7F};
    send_region();
    frame_bytes = {szhp_pkg::ID_UNPACK_INFO, szhp_pkg::ID_FOLDER, 8'h01, 8'h00, 8'h01, 8'h23,
                   8'h03, 8'h01, 8'h01, 8'h01, 8'hE1};
    send_region();
    frame_bytes = {8'h00, 8'h01};
    send_region();
    frame_bytes = {szhp_pkg::ID_UNPACK_INFO, szhp_pkg::ID_FOLDER, 8'h01, 8'h00, 8'h01, 8'h00};
    send_region();
    frame_bytes = {szhp_pkg::ID_PACK_INFO, 8'h00, 8'h00, 8'h00};
    send_region();
    frame_bytes = {szhp_pkg::ID_UNPACK_INFO};
    send_region();
    drain();

    // Limits of one, the largest limits and limits of zero, then five random settings.
    for (int phase_no = 0; phase_no < 8; phase_no++) begin
      case (phase_no)
        0: begin
          write_reg(szhp_pkg::CFG_STEP_LIMIT, 16'd1);
          write_reg(szhp_pkg::CFG_PACK_LIMIT, 16'd1);
        end
        1: begin
          write_reg(szhp_pkg::CFG_STEP_LIMIT, 16'd255);
          write_reg(szhp_pkg::CFG_PACK_LIMIT, 16'hFFFF);
        end
        2: begin
          write_reg(szhp_pkg::CFG_STEP_LIMIT, 16'd0);
          write_reg(szhp_pkg::CFG_PACK_LIMIT, 16'd0);
        end
        default: begin
          write_reg(szhp_pkg::CFG_STEP_LIMIT, 16'($urandom_range(2, 12)));
          write_reg(szhp_pkg::CFG_PACK_LIMIT, 16'($urandom_range(1, 3)));
        end
      endcase
      allow_gaps = (phase_no != 1);
      sent = 0;
      while (sent < 150) begin
        if (phase_no == 4 && !hold_started && sent >= 40) begin
          // Long receiver hold-off while bytes keep coming.
          hold_started = 1'b1;
          hold_output = 1'b1;
          fork
            begin
              repeat (60) @(negedge clk_i);
              hold_output = 1'b0;
            end
          join_none
        end
        if ($urandom_range(0, 9) == 0) begin
          frame_bytes.delete();
          repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
        end else build_header($urandom_range(0, 4) == 0);
        send_region();
        sent += frame_bytes.size();
      end
      drain();
    end
    if (errors == 0) $display("sevenzip_coded_header_probe regression: pass");
    else $display("sevenzip_coded_header_probe regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
design/szhp_pkg.sv
design/szhp_number.sv
design/sevenzip_coded_header_probe.sv
verif/sevenzip_coded_header_checker.sv
verif/sevenzip_coded_header_probe_test.sv
